// ===== rtl/rship_pkg.sv =====
`default_nettype none

package rship_pkg;

    // field widths of the stream words
    localparam int REQ_SET_W = 11;
    localparam int REQ_WAY_W = 4;
    localparam int RSP_WAY_W = 4;
    localparam int ADDR_W    = 64;

    // block address and signature positions
    localparam int BLK_LSB = 6;
    localparam int BLK_W   = 32;
    localparam int SIG_LSB = 2;

    // decay period register
    localparam int                 DECAY_W     = 17;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 17'd100000;

    // configuration port
    localparam int         PADDR_W          = 3;
    localparam int         PDATA_W          = 32;
    localparam logic [0:0] REG_DECAY_PERIOD = 1'b0;

    // re-reference values and reuse counter limits
    localparam logic [1:0] RRPV_MAX  = 2'd3;
    localparam logic [1:0] RRPV_LONG = 2'd2;
    localparam logic [1:0] RRPV_NEAR = 2'd0;
    localparam logic [1:0] CTR_MAX   = 2'd3;
    localparam logic [1:0] CTR_ZERO  = 2'd0;
    localparam logic [1:0] CTR_ONE   = 2'd1;

    typedef struct packed {
        logic [REQ_SET_W-1:0] set_index;
        logic [ADDR_W-1:0]    pc;
        logic [ADDR_W-1:0]    phys_addr;
        logic                 hit;
        logic [REQ_WAY_W-1:0] hit_way;
    } req_word_t;

    typedef struct packed {
        logic [RSP_WAY_W-1:0] chosen_way;
        logic                 set_streaming;
        logic [1:0]           new_rrpv;
    } rsp_word_t;

    typedef struct packed {
        logic accept;
        logic commit;
        logic clearing;
        logic decaying;
    } dp_cmd_t;

    typedef struct packed {
        logic decay_due;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rship_ram.sv =====
`default_nettype none

module rship_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/rship_ctrl.sv =====
`default_nettype none

module rship_ctrl #(
    parameter int NUM_SETS = 2048,
    parameter int SIG_BITS = 6,
    parameter int IDX_W    = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    input  wire rship_pkg::dp_stat_t stat,
    output rship_pkg::dp_cmd_t       cmd,
    output logic [IDX_W-1:0]         idx
);

    import rship_pkg::*;

    localparam int SIG_COUNT = 1 << SIG_BITS;
    localparam int CLR_LEN   = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_DECAY = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             commit;

    // result can only be loaded when the output word is free or leaving
    assign commit = (state_reg == ST_CALC) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(CLR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (commit)
                begin
                    state_next = stat.decay_due ? ST_DECAY : ST_IDLE;
                end
            end
            ST_DECAY:
            begin
                // the last step only writes back the final read-modify-write
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(SIG_COUNT))
                begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    assign rsp_valid_next = commit || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign idx          = idx_reg;
    assign cmd.accept   = (state_reg == ST_IDLE) && req_valid;
    assign cmd.commit   = commit;
    assign cmd.clearing = (state_reg == ST_CLEAR);
    assign cmd.decaying = (state_reg == ST_DECAY);

endmodule

`default_nettype wire

// ===== rtl/rship_dp.sv =====
`default_nettype none

module rship_dp #(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16,
    parameter int SIG_BITS = 6,
    parameter int IDX_W    = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire rship_pkg::req_word_t                req,
    input  wire rship_pkg::dp_cmd_t                  cmd,
    input  wire logic [IDX_W-1:0]                    idx,
    input  wire logic [rship_pkg::DECAY_W-1:0]       decay_period,
    output rship_pkg::dp_stat_t                      stat,
    output rship_pkg::rsp_word_t                     rsp
);

    import rship_pkg::*;

    localparam int SIG_COUNT  = 1 << SIG_BITS;
    localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W      = $clog2(NUM_WAYS);
    localparam int RR_W       = 2 * NUM_WAYS;
    localparam int FLAG_POS   = RR_W;
    localparam int BLK_POS    = RR_W + 1;
    localparam int VALID_POS  = RR_W + 1 + BLK_W;
    localparam int SET_WORD_W = RR_W + 2 + BLK_W;

    // set index modulo NUM_SETS by conditional subtraction of shifted multiples
    function automatic logic [SET_W-1:0] wrap_set(input logic [REQ_SET_W-1:0] x);
        logic [REQ_SET_W-1:0] r;
        int unsigned          stepv;
        r = x;
        for (int j = REQ_SET_W - 1; j >= 0; j--)
        begin
            stepv = NUM_SETS << j;
            if ((stepv < (1 << REQ_SET_W)) && (32'(r) >= stepv))
            begin
                r = r - REQ_SET_W'(stepv);
            end
        end
        return SET_W'(r);
    endfunction

    function automatic logic [WAY_W-1:0] wrap_way(input logic [REQ_WAY_W-1:0] x);
        logic [REQ_WAY_W-1:0] r;
        int unsigned          stepv;
        r = x;
        for (int j = REQ_WAY_W - 1; j >= 0; j--)
        begin
            stepv = NUM_WAYS << j;
            if ((stepv < (1 << REQ_WAY_W)) && (32'(r) >= stepv))
            begin
                r = r - REQ_WAY_W'(stepv);
            end
        end
        return WAY_W'(r);
    endfunction

    // item registers
    logic [SET_W-1:0]    set_idx_reg;
    logic [SIG_BITS-1:0] sig_reg;
    logic [BLK_W-1:0]    blk_reg;
    logic                hit_reg;
    logic [WAY_W-1:0]    hway_reg;
    logic [DECAY_W-1:0]  acc_reg, acc_next;
    rsp_word_t           rsp_reg, rsp_next;

    // memory ports
    logic                  set_we;
    logic [SET_W-1:0]      set_waddr, set_raddr;
    logic [SET_WORD_W-1:0] set_wdata, set_rdata, clr_word;
    logic                  cnt_we;
    logic [SIG_BITS-1:0]   cnt_waddr, cnt_raddr;
    logic [1:0]            cnt_wdata, cnt_rdata;
    logic [IDX_W-1:0]      idx_m1;
    logic                  clr_set, clr_cnt;

    // replacement datapath
    logic [1:0]         rr [NUM_WAYS];
    logic               any3, any2, any1;
    logic [1:0]         rr_top, age;
    logic [WAY_W-1:0]   victim, way;
    logic [RR_W-1:0]    rr_new;
    logic [BLK_W-1:0]   last_blk, delta;
    logic               flag_new;
    logic [1:0]         ctr_upd, ctr_eff, ins;
    logic [DECAY_W-1:0] acc_inc;
    logic               decay_due;

    rship_ram #(
        .WIDTH (SET_WORD_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (set_we),
        .waddr (set_waddr),
        .wdata (set_wdata),
        .raddr (set_raddr),
        .rdata (set_rdata)
    );

    rship_ram #(
        .WIDTH (2),
        .DEPTH (SIG_COUNT)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // victim: first way holding the set's highest value, aged up to 3
    always_comb
    begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            rr[w] = set_rdata[2*w +: 2];
            any3  = any3 | (rr[w] == RRPV_MAX);
            any2  = any2 | (rr[w] == 2'd2);
            any1  = any1 | (rr[w] == 2'd1);
        end
        priority if (any3)
            rr_top = 2'd3;
        else if (any2)
            rr_top = 2'd2;
        else if (any1)
            rr_top = 2'd1;
        else
            rr_top = 2'd0;
        age    = RRPV_MAX - rr_top;
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (rr[w] == rr_top)
            begin
                victim = WAY_W'(w);
            end
        end
    end

    assign way = hit_reg ? hway_reg : victim;

    // stream detector
    assign last_blk = set_rdata[BLK_POS +: BLK_W];
    assign delta    = blk_reg - last_blk;

    always_comb
    begin
        flag_new = set_rdata[FLAG_POS];
        if (set_rdata[VALID_POS])
        begin
            priority if ((delta == BLK_W'(1)) || (delta == '1))
                flag_new = 1'b1;
            else if (delta != '0)
                flag_new = 1'b0;
            else
                flag_new = set_rdata[FLAG_POS];
        end
    end

    // reuse counter and decay timing
    assign acc_inc   = acc_reg + 1'b1;
    assign decay_due = (acc_inc >= decay_period);
    assign acc_next  = decay_due ? '0 : acc_inc;

    always_comb
    begin
        if (hit_reg)
            ctr_upd = (cnt_rdata == CTR_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
        else
            ctr_upd = (cnt_rdata == CTR_ZERO) ? cnt_rdata : cnt_rdata - 1'b1;
        ctr_eff = (decay_due && (ctr_upd != CTR_ZERO)) ? ctr_upd - 1'b1 : ctr_upd;
        priority if (hit_reg)
            ins = RRPV_NEAR;
        else if (flag_new)
            ins = RRPV_MAX;
        else if (ctr_eff == CTR_ZERO)
            ins = RRPV_MAX;
        else if (ctr_eff == CTR_ONE)
            ins = RRPV_LONG;
        else
            ins = RRPV_NEAR;
    end

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (WAY_W'(w) == way)
                rr_new[2*w +: 2] = ins;
            else if (hit_reg)
                rr_new[2*w +: 2] = rr[w];
            else
                rr_new[2*w +: 2] = rr[w] + age;
        end
    end

    // memory addressing
    always_comb
    begin
        clr_word           = '0;
        clr_word[RR_W-1:0] = '1;
    end

    assign idx_m1  = idx - 1'b1;
    assign clr_set = cmd.clearing && ({1'b0, idx} < (IDX_W + 1)'(NUM_SETS));
    assign clr_cnt = cmd.clearing && ({1'b0, idx} < (IDX_W + 1)'(SIG_COUNT));

    assign set_raddr = cmd.accept ? wrap_set(req.set_index) : set_idx_reg;
    assign set_we    = cmd.commit || clr_set;
    assign set_waddr = cmd.clearing ? idx[SET_W-1:0] : set_idx_reg;
    assign set_wdata = cmd.clearing ? clr_word : {1'b1, blk_reg, flag_new, rr_new};

    always_comb
    begin
        priority if (cmd.decaying)
            cnt_raddr = idx[SIG_BITS-1:0];
        else if (cmd.accept)
            cnt_raddr = req.pc[SIG_LSB +: SIG_BITS];
        else
            cnt_raddr = sig_reg;
    end

    // the sweep decrements every counter, including the one just written
    always_comb
    begin
        priority if (cmd.clearing)
        begin
            cnt_we    = clr_cnt;
            cnt_waddr = idx[SIG_BITS-1:0];
            cnt_wdata = CTR_ZERO;
        end
        else if (cmd.decaying)
        begin
            cnt_we    = (idx != '0);
            cnt_waddr = idx_m1[SIG_BITS-1:0];
            cnt_wdata = (cnt_rdata == CTR_ZERO) ? cnt_rdata : cnt_rdata - 1'b1;
        end
        else
        begin
            cnt_we    = cmd.commit;
            cnt_waddr = sig_reg;
            cnt_wdata = ctr_upd;
        end
    end

    assign rsp_next.chosen_way    = RSP_WAY_W'(way);
    assign rsp_next.set_streaming = flag_new;
    assign rsp_next.new_rrpv      = ins;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_idx_reg <= wrap_set(req.set_index);
            sig_reg     <= req.pc[SIG_LSB +: SIG_BITS];
            blk_reg     <= req.phys_addr[BLK_LSB +: BLK_W];
            hit_reg     <= req.hit;
            hway_reg    <= wrap_way(req.hit_way);
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.commit)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat.decay_due = decay_due;
    assign rsp            = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/rrip_ship_stream_replacement.sv =====
// Channel  Dir  Word        Handshake
// req      in   req_word_t  req_valid / req_stall
// rsp      out  rsp_word_t  rsp_valid / rsp_stall
// apb      in   decay_period at byte address 0, pready tied high
//
// Each access passes through states IDLE and CALC: IDLE reads the set and counter memories,
// CALC picks the way, updates and writes both back and loads the output word.
// Every decay_period accesses a decay sweep over the counter memory follows, one
// read-modify-write per cycle. After reset a clearing pass over every address
// initialises both memories; req_stall is high meanwhile.
// A stalled rsp holds the result; the next access is taken alongside it.
`default_nettype none

module rrip_ship_stream_replacement #(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16,
    parameter int SIG_BITS = 6
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire rship_pkg::req_word_t              req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output rship_pkg::rsp_word_t                   rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rship_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [rship_pkg::PDATA_W-1:0]     pwdata,
    output logic      [rship_pkg::PDATA_W-1:0]     prdata,
    output logic                                   pready
);

    import rship_pkg::*;

    localparam int SIG_COUNT = 1 << SIG_BITS;
    localparam int CLR_LEN   = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
    localparam int IDX_MAX   = (CLR_LEN - 1 > SIG_COUNT) ? CLR_LEN - 1 : SIG_COUNT;
    localparam int IDX_W     = $clog2(IDX_MAX + 1);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [IDX_W-1:0]   idx;
    logic [DECAY_W-1:0] decay_period_reg;
    logic               reg_sel;
    logic               reg_wr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_DECAY_PERIOD);
    assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? PDATA_W'(decay_period_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_period_reg <= DECAY_RESET;
        end
        else if (reg_wr)
        begin
            decay_period_reg <= pwdata[DECAY_W-1:0];
        end
    end

    rship_ctrl #(
        .NUM_SETS (NUM_SETS),
        .SIG_BITS (SIG_BITS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd),
        .idx       (idx)
    );

    rship_dp #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .SIG_BITS (SIG_BITS),
        .IDX_W    (IDX_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cmd          (cmd),
        .idx          (idx),
        .decay_period (decay_period_reg),
        .stat         (stat),
        .rsp          (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/rship_checker.sv =====
`default_nettype none

module rship_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_stall,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_stall,
    input wire rship_pkg::rsp_word_t rsp
);

    import rship_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp word changed while stalled");

    // one access in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second word taken before the first finished");

    a_rrpv_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.new_rrpv != 2'd1)
        else $error("insertion value 1 is never written");

    // a streaming set never inserts at long re-reference
    a_long_not_streaming: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.new_rrpv == RRPV_LONG |-> !rsp.set_streaming)
        else $error("long insertion on a streaming set");

endmodule

bind rrip_ship_stream_replacement rship_checker u_rship_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== sim/rrip_ship_stream_replacement_test.sv =====
module rrip_ship_stream_replacement_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rship_pkg::*;

    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int SIG_BITS     = 6;
    localparam int SIG_COUNT    = 1 << SIG_BITS;
    localparam int SWEEP_CYCLES = SIG_COUNT + 16;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 110;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        req_word_t word;
        logic      typed;
        rsp_word_t want;
    } access_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_word_t            req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_word_t            rsp;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // mirror of the replacement state
    logic [1:0]         rrpv_mem [NUM_SETS][NUM_WAYS];
    logic               stream_flag [NUM_SETS];
    logic [BLK_W-1:0]   last_blk [NUM_SETS];
    logic               last_seen [NUM_SETS];
    logic [1:0]         reuse_level [SIG_COUNT];
    logic [DECAY_W-1:0] access_count;
    logic [DECAY_W-1:0] decay_period;

    rsp_word_t          predicted_rsp [$];
    access_row_t        directed_rows [$];
    logic [REQ_SET_W-1:0] set_pool [8];
    logic [SIG_BITS-1:0]  sig_pool [4];
    logic [DECAY_W-1:0]   decay_settings [PHASES];

    int  failures        = 0;
    int  cycles          = 0;
    int  accesses_sent   = 0;
    int  misses_sent     = 0;
    int  streaming_seen  = 0;
    int  results_seen    = 0;
    bit  sender_quiet    = 1'b0;
    bit  receiver_quiet  = 1'b0;

    rrip_ship_stream_replacement i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, predicted_rsp.size());
            $display("FAIL rrip_ship_stream_replacement");
            $finish;
        end
    end

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    function automatic access_row_t row(input logic [REQ_SET_W-1:0] set_index,
                                        input logic [ADDR_W-1:0] pc,
                                        input logic [ADDR_W-1:0] phys_addr,
                                        input logic hit,
                                        input logic [REQ_WAY_W-1:0] hit_way,
                                        input logic typed,
                                        input logic [RSP_WAY_W-1:0] way,
                                        input logic streaming,
                                        input logic [1:0] rrpv);
        access_row_t r;
        r.word.set_index    = set_index;
        r.word.pc           = pc;
        r.word.phys_addr    = phys_addr;
        r.word.hit          = hit;
        r.word.hit_way      = hit_way;
        r.typed             = typed;
        r.want.chosen_way   = way;
        r.want.set_streaming = streaming;
        r.want.new_rrpv     = rrpv;
        return r;
    endfunction

    // victim choice, stream detection, reuse counter, decay and insertion for one access
    function automatic rsp_word_t predict_access(input req_word_t w);
        int               s;
        int               way;
        int               v;
        int               round;
        int               sig;
        bit               found;
        logic [BLK_W-1:0] blk;
        logic [BLK_W-1:0] delta;
        logic [1:0]       ins;
        rsp_word_t        r;

        s = int'(w.set_index) % NUM_SETS;
        way = 0;
        if (w.hit)
            way = int'(w.hit_way) % NUM_WAYS;
        else
        begin
            found = 1'b0;
            for (round = 0; round < 4 && !found; round++)
            begin
                for (v = 0; v < NUM_WAYS && !found; v++)
                    if (rrpv_mem[s][v] == RRPV_MAX)
                    begin
                        way = v;
                        found = 1'b1;
                    end
                if (!found)
                    for (v = 0; v < NUM_WAYS; v++)
                        if (rrpv_mem[s][v] < RRPV_MAX)
                            rrpv_mem[s][v]++;
            end
        end

        blk = w.phys_addr[BLK_LSB +: BLK_W];
        if (last_seen[s])
        begin
            delta = blk - last_blk[s];
            if (delta == BLK_W'(1) || delta == '1)
                stream_flag[s] = 1'b1;
            else if (delta != '0)
                stream_flag[s] = 1'b0;
        end
        last_blk[s]  = blk;
        last_seen[s] = 1'b1;

        sig = int'(w.pc[SIG_LSB +: SIG_BITS]);
        if (w.hit)
        begin
            if (reuse_level[sig] != CTR_MAX)
                reuse_level[sig]++;
        end
        else if (reuse_level[sig] != CTR_ZERO)
            reuse_level[sig]--;

        access_count = access_count + 1'b1;
        if (access_count >= decay_period)
        begin
            access_count = '0;
            for (v = 0; v < SIG_COUNT; v++)
                if (reuse_level[v] != CTR_ZERO)
                    reuse_level[v]--;
        end

        if (w.hit)
            ins = RRPV_NEAR;
        else if (stream_flag[s])
            ins = RRPV_MAX;
        else if (reuse_level[sig] == CTR_ZERO)
            ins = RRPV_MAX;
        else if (reuse_level[sig] == CTR_ONE)
            ins = RRPV_LONG;
        else
            ins = RRPV_NEAR;
        rrpv_mem[s][way] = ins;

        r.chosen_way    = RSP_WAY_W'(way);
        r.set_streaming = stream_flag[s];
        r.new_rrpv      = ins;
        return r;
    endfunction

    // mostly a few hot sets and signatures, addresses mostly one block either side
    function automatic req_word_t make_access();
        req_word_t        w;
        logic [BLK_W-1:0] blk;
        int               pick;

        if ($urandom_range(0, 99) < 85)
            w.set_index = set_pool[$urandom_range(0, 7)];
        else
            w.set_index = REQ_SET_W'($urandom);
        w.pc = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 85)
            w.pc[SIG_LSB +: SIG_BITS] = sig_pool[$urandom_range(0, 3)];
        w.phys_addr = {$urandom, $urandom};
        blk = last_blk[w.set_index];
        pick = $urandom_range(0, 99);
        if (pick < 35)
            w.phys_addr[BLK_LSB +: BLK_W] = blk + 1'b1;
        else if (pick < 55)
            w.phys_addr[BLK_LSB +: BLK_W] = blk - 1'b1;
        else if (pick < 62)
            w.phys_addr[BLK_LSB +: BLK_W] = blk;
        w.hit     = ($urandom_range(0, 99) < 45);
        w.hit_way = REQ_WAY_W'($urandom);
        return w;
    endfunction

    task automatic send_access(input req_word_t w, input logic typed, input rsp_word_t want);
        int        gap;
        rsp_word_t predicted;

        if (accesses_sent % 40 == 0)
            sender_quiet = ($urandom_range(0, 3) == 0);
        gap = sender_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predicted = predict_access(w);
        predicted_rsp.push_back(typed ? want : predicted);
        accesses_sent++;
        if (!w.hit)
            misses_sent++;
    endtask

    task automatic drain_results(input int extra);
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_rsp.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_decay(input logic [DECAY_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_DECAY_PERIOD) << 2;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        decay_period = value;
        // read it back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata != PDATA_W'(value))
            report_failure($sformatf("decay_period readback: expected %0d, got %0d",
                                     value, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver: random stall ahead of each word, then check it
    initial
    begin
        int        n;
        rsp_word_t want;

        wait (rst_n);
        forever
        begin
            if (results_seen % 32 == 0)
                receiver_quiet = ($urandom_range(0, 3) == 0);
            n = receiver_quiet ? 0 : $urandom_range(0, 15);
            if (n != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            results_seen++;
            if (rsp.set_streaming)
                streaming_seen++;
            if (predicted_rsp.size() == 0)
                report_failure($sformatf("unexpected word: way %0d streaming %0b rrpv %0d",
                                         rsp.chosen_way, rsp.set_streaming, rsp.new_rrpv));
            else
            begin
                want = predicted_rsp.pop_front();
                if (rsp.chosen_way != want.chosen_way
                    || rsp.set_streaming != want.set_streaming
                    || rsp.new_rrpv != want.new_rrpv)
                    report_failure($sformatf(
                        "word %0d way/stream/rrpv: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                        results_seen, want.chosen_way, want.set_streaming, want.new_rrpv,
                        rsp.chosen_way, rsp.set_streaming, rsp.new_rrpv));
            end
        end
    end

    initial
    begin
        int phase;
        int n;

        for (int s = 0; s < NUM_SETS; s++)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
                rrpv_mem[s][w] = RRPV_MAX;
            stream_flag[s] = 1'b0;
            last_blk[s]    = '0;
            last_seen[s]   = 1'b0;
        end
        for (int g = 0; g < SIG_COUNT; g++)
            reuse_level[g] = CTR_ZERO;
        access_count = '0;
        decay_period = DECAY_RESET;

        decay_settings = '{17'd1, 17'd131071, 17'd0, 17'd5, 17'd2, 17'd0};
        decay_settings[PHASES-1] = DECAY_W'($urandom_range(3, 60));

        directed_rows = '{
            // fresh set: way 0 taken, first address leaves the flag alone
            row(11'd0, 64'd0, 64'h0, 1'b0, 4'd0, 1'b1, 4'd0, 1'b0, RRPV_MAX),
            row(11'd0, 64'd0, 64'h40, 1'b0, 4'd0, 1'b1, 4'd0, 1'b1, RRPV_MAX),
            row(11'd0, 64'd0, 64'h0, 1'b0, 4'd0, 1'b1, 4'd0, 1'b1, RRPV_MAX),
            // same block keeps the flag
            row(11'd0, 64'd0, 64'h0, 1'b1, 4'd15, 1'b1, 4'd15, 1'b1, RRPV_NEAR),
            row(11'd0, 64'd0, 64'h140, 1'b0, 4'd0, 1'b1, 4'd0, 1'b0, RRPV_MAX),
            row(11'd2047, '1, '1, 1'b1, 4'd15, 1'b1, 4'd15, 1'b0, RRPV_NEAR),
            row(11'd2047, '1, '1, 1'b0, 4'd0, 1'b1, 4'd0, 1'b0, RRPV_MAX),
            // block address wraps from all ones to zero
            row(11'd2047, '1, 64'hFFFF_FFC0_0000_003F, 1'b0, 4'd0, 1'b1, 4'd0, 1'b1, RRPV_MAX),
            // saturate one counter, then walk it down through every insertion value
            row(11'd3, 64'd4, 64'h1000, 1'b1, 4'd0, 1'b1, 4'd0, 1'b0, RRPV_NEAR),
            row(11'd3, 64'd4, 64'h1000, 1'b1, 4'd1, 1'b1, 4'd1, 1'b0, RRPV_NEAR),
            row(11'd3, 64'd4, 64'h1000, 1'b1, 4'd2, 1'b1, 4'd2, 1'b0, RRPV_NEAR),
            row(11'd3, 64'd4, 64'h1000, 1'b0, 4'd0, 1'b1, 4'd3, 1'b0, RRPV_NEAR),
            row(11'd3, 64'd4, 64'h1000, 1'b0, 4'd0, 1'b1, 4'd4, 1'b0, RRPV_LONG),
            row(11'd3, 64'd4, 64'h1000, 1'b0, 4'd0, 1'b1, 4'd5, 1'b0, RRPV_MAX),
            row(11'd3, 64'd4, 64'h1000, 1'b1, 4'd3, 1'b0, 4'd0, 1'b0, RRPV_NEAR),
            row(11'd3, 64'd4, 64'h1040, 1'b0, 4'd0, 1'b0, 4'd0, 1'b0, RRPV_NEAR),
            row(11'h555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 4'hA,
                1'b0, 4'd0, 1'b0, RRPV_NEAR),
            row(11'h2AA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 4'h5,
                1'b0, 4'd0, 1'b0, RRPV_NEAR)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_access(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results(SWEEP_CYCLES);
            write_decay(decay_settings[phase]);
            foreach (set_pool[i])
                set_pool[i] = REQ_SET_W'($urandom);
            set_pool[0] = phase[0] ? '0 : '1;
            foreach (sig_pool[i])
                sig_pool[i] = SIG_BITS'($urandom);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    drain_results(0);
                send_access(make_access(), 1'b0, '0);
            end
        end

        drain_results(SWEEP_CYCLES);
        if (predicted_rsp.size() != 0)
            report_failure($sformatf("%0d words never arrived", predicted_rsp.size()));
        $display("%0d accesses (%0d misses), %0d words checked, %0d with the set streaming",
                 accesses_sent, misses_sent, results_seen, streaming_seen);
        $display("decay period at reset value plus %0d settings, 0 and 131071 among them",
                 PHASES);
        if (failures == 0)
            $display("PASS rrip_ship_stream_replacement");
        else
            $display("FAIL rrip_ship_stream_replacement");
        $finish;
    end

endmodule
